// ===== rtl/u8v_pkg.sv =====
// ----------------------------------------------------------------------------
// u8v_pkg
// Types and byte constants shared by the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

  typedef enum logic [1:0] {
    VERDICT_VALID     = 2'd0,
    VERDICT_INVALID   = 2'd1,
    VERDICT_TRUNCATED = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } byte_word_t;

  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF7;
  localparam logic [7:0] LEAD5_MIN = 8'hF8;
  localparam logic [7:0] LEAD5_MAX = 8'hFB;
  localparam logic [7:0] LEAD6_MIN = 8'hFC;
  localparam logic [7:0] LEAD6_MAX = 8'hFD;
  localparam logic [7:0] CONT_MIN  = 8'h80;
  localparam logic [7:0] CONT_MAX  = 8'hBF;
  localparam logic [7:0] FIRST_MIN3 = 8'hA0;
  localparam logic [7:0] FIRST_MIN4 = 8'h90;
  localparam logic [7:0] FIRST_MIN5 = 8'h88;
  localparam logic [7:0] FIRST_MIN6 = 8'h84;

endpackage

// ===== rtl/u8v_in_if.sv =====
// ----------------------------------------------------------------------------
// u8v_in_if
// Byte channel into the validator: one byte and its end-of-string flag.
// ----------------------------------------------------------------------------
interface u8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

// ===== rtl/u8v_out_if.sv =====
// ----------------------------------------------------------------------------
// u8v_out_if
// Result channel of the validator: verdict and missing byte count.
// ----------------------------------------------------------------------------
interface u8v_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [2:0] bytes_missing;

  modport source (output valid, output verdict, output bytes_missing, input ready);
  modport sink   (input valid, input verdict, input bytes_missing, output ready);
endinterface

// ===== rtl/u8v_in_reg.sv =====
// ----------------------------------------------------------------------------
// u8v_in_reg
// Input register: holds one byte word until the checker takes it.
// ----------------------------------------------------------------------------
module u8v_in_reg
  import u8v_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  u8v_in_if.sink      in_ch,
  output logic        word_vld,
  output byte_word_t  word,
  input  logic        word_take
);

  logic       vld_r;
  logic       vld_nxt;
  byte_word_t word_r;
  logic       load;

  assign in_ch.ready = !vld_r || word_take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (word_take) begin
      vld_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r.data_byte     <= in_ch.data_byte;
      word_r.end_of_string <= in_ch.end_of_string;
    end
  end

  assign word_vld = vld_r;
  assign word     = word_r;

endmodule

// ===== rtl/u8v_check.sv =====
// ----------------------------------------------------------------------------
// u8v_check
// Sequence state, byte classification and the registered verdict.
// ----------------------------------------------------------------------------
module u8v_check
  import u8v_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        word_vld,
  input  byte_word_t  word,
  output logic        word_take,
  u8v_out_if.source   out_ch
);

  typedef struct packed {
    logic       bad;
    logic [2:0] count;
    logic [7:0] minimum;
  } lead_t;

  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t d;
    d = '{bad: 1'b0, count: 3'd0, minimum: CONT_MIN};
    unique case (b) inside
      [8'h00:ASCII_MAX]:                  d.count = 3'd0;
      [LEAD2_MIN:LEAD2_MAX]:              d.count = 3'd1;
      LEAD3_MIN:                          begin d.count = 3'd2; d.minimum = FIRST_MIN3; end
      [LEAD3_MIN + 8'd1:LEAD3_MAX]:       d.count = 3'd2;
      LEAD4_MIN:                          begin d.count = 3'd3; d.minimum = FIRST_MIN4; end
      [LEAD4_MIN + 8'd1:LEAD4_MAX]:       d.count = 3'd3;
      LEAD5_MIN:                          begin d.count = 3'd4; d.minimum = FIRST_MIN5; end
      [LEAD5_MIN + 8'd1:LEAD5_MAX]:       d.count = 3'd4;
      LEAD6_MIN:                          begin d.count = 3'd5; d.minimum = FIRST_MIN6; end
      [LEAD6_MIN + 8'd1:LEAD6_MAX]:       d.count = 3'd5;
      default:                            d.bad = 1'b1;
    endcase
    return d;
  endfunction

  logic [2:0] pend_r,     pend_nxt;
  logic [7:0] min_r,      min_nxt;
  logic       str_bad_r,  str_bad_nxt;
  logic       seq_bad_r,  seq_bad_nxt;
  logic       out_vld_r,  out_vld_nxt;
  verdict_t   verdict_r,  verdict_nxt;
  logic [2:0] missing_r,  missing_nxt;
  lead_t      lead;
  logic       cont_bad;
  logic       seq_bad_acc;
  logic       out_free;

  assign out_free  = !out_vld_r || out_ch.ready;
  assign word_take = word_vld && (!word.end_of_string || out_free);

  assign lead        = lead_decode(word.data_byte);
  assign cont_bad    = (word.data_byte < min_r) || (word.data_byte > CONT_MAX);
  assign seq_bad_acc = seq_bad_r || cont_bad;

  always_comb begin
    pend_nxt    = pend_r;
    min_nxt     = min_r;
    str_bad_nxt = str_bad_r;
    seq_bad_nxt = seq_bad_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    verdict_nxt = verdict_r;
    missing_nxt = missing_r;
    if (word_take) begin
      if (pend_r == 3'd0) begin
        if (lead.bad) begin
          str_bad_nxt = 1'b1;
        end else if (lead.count != 3'd0) begin
          pend_nxt    = lead.count;
          min_nxt     = lead.minimum;
          seq_bad_nxt = 1'b0;
        end
      end else begin
        pend_nxt = pend_r - 3'd1;
        min_nxt  = CONT_MIN;
        if (pend_r == 3'd1) begin
          str_bad_nxt = str_bad_r || seq_bad_acc;
          seq_bad_nxt = 1'b0;
        end else begin
          seq_bad_nxt = seq_bad_acc;
        end
      end
      if (word.end_of_string) begin
        out_vld_nxt = 1'b1;
        missing_nxt = 3'd0;
        if (str_bad_nxt) begin
          verdict_nxt = VERDICT_INVALID;
        end else if (pend_nxt != 3'd0) begin
          verdict_nxt = VERDICT_TRUNCATED;
          missing_nxt = pend_nxt;
        end else begin
          verdict_nxt = VERDICT_VALID;
        end
        pend_nxt    = 3'd0;
        min_nxt     = CONT_MIN;
        str_bad_nxt = 1'b0;
        seq_bad_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 3'd0;
      min_r     <= CONT_MIN;
      str_bad_r <= 1'b0;
      seq_bad_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      pend_r    <= pend_nxt;
      min_r     <= min_nxt;
      str_bad_r <= str_bad_nxt;
      seq_bad_r <= seq_bad_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
    missing_r <= missing_nxt;
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.verdict       = verdict_r;
  assign out_ch.bytes_missing = missing_r;

endmodule

// ===== rtl/utf8_stream_validator.sv =====
// The validator checks a string of UTF-8 bytes, the old five- and six-byte
// forms included, and gives one result word on the byte flagged as the end of
// the string: valid, invalid, or truncated with the count of continuation
// bytes still missing. It takes one byte word per cycle while no end-of-string
// byte stalls; a byte passes an input register and then a result register
// before its verdict is presented. Bytes keep flowing while a verdict waits to
// be taken; only a further end-of-string byte stalls until the result register
// frees.
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Top level: input register followed by the sequence checker.
// ----------------------------------------------------------------------------
module utf8_stream_validator
  import u8v_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  u8v_in_if.sink    in_ch,
  u8v_out_if.source out_ch
);

  logic       word_vld;
  byte_word_t word;
  logic       word_take;

  u8v_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .word_vld  (word_vld),
    .word      (word),
    .word_take (word_take)
  );

  u8v_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .word_vld  (word_vld),
    .word      (word),
    .word_take (word_take),
    .out_ch    (out_ch)
  );

endmodule
